### rtl/woi_pkg.sv
// ----------------------------------------------------------------------------
// woi_pkg - shared definitions for the wheel odometry integrator
// Operand widths of the serial arithmetic units, register indexes, the CORDIC
// angle table and the saturation helpers.
// ----------------------------------------------------------------------------
package woi_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CI_W         = $clog2(CORDIC_STEPS + 1);

	localparam int MUL_A_W = 64;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 24;

	localparam logic REG_DIST_PER_COUNT = 1'b0;
	localparam logic REG_TURN_GAIN      = 1'b1;

	localparam logic [31:0] DPC_RESET  = 32'd2319282;
	localparam logic [31:0] GAIN_RESET = 32'd67016204;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

	function automatic logic [31:0] atan_lut(input logic [4:0] k);
		logic [31:0] v;
		case (k)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// Add a 64-bit signed increment to a 32-bit accumulator, clamping the sum.
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] d);
		logic signed [63:0] s;
		s = $signed({{32{a[31]}}, a}) + $signed(d);
		if (s > 64'sh7FFFFFFF)
			return 32'h7FFFFFFF;
		else if (s < -64'sh80000000)
			return 32'h80000000;
		else
			return s[31:0];
	endfunction

	// Apply a sign to an unsigned magnitude and clamp to the signed 32-bit range.
	function automatic logic [31:0] sat_rate(input logic neg, input logic [63:0] q);
		logic [31:0] r;
		if (!neg)
			r = (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
		else
			r = (q >= 64'h80000000) ? 32'h80000000 : 32'(-q[31:0]);
		return r;
	endfunction

endpackage

### rtl/woi_mul.sv
// ----------------------------------------------------------------------------
// woi_mul - bit-serial unsigned multiplier
// Shift-and-add over one multiplier bit per cycle; the full product is held
// once done pulses.
// ----------------------------------------------------------------------------
module woi_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [woi_pkg::MUL_A_W-1:0]   a,
	input  logic [woi_pkg::MUL_B_W-1:0]   b,
	output logic                          done,
	output logic [woi_pkg::MUL_P_W-1:0]   p
);

	localparam int CNT_W = $clog2(woi_pkg::MUL_B_W);

	logic [woi_pkg::MUL_A_W-1:0] a_q;
	logic [woi_pkg::MUL_P_W-1:0] p_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [woi_pkg::MUL_A_W:0]   sum;

	always_comb begin
		sum = {1'b0, p_q[woi_pkg::MUL_P_W-1:woi_pkg::MUL_B_W]}
			+ (p_q[0] ? {1'b0, a_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(woi_pkg::MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{woi_pkg::MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[woi_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

### rtl/woi_div.sv
// ----------------------------------------------------------------------------
// woi_div - bit-serial restoring divider
// One quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module woi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [woi_pkg::DIV_N_W-1:0]   n,
	input  logic [woi_pkg::DIV_D_W-1:0]   d,
	output logic                          done,
	output logic [woi_pkg::DIV_N_W-1:0]   q
);

	localparam int CNT_W = $clog2(woi_pkg::DIV_N_W);

	logic [woi_pkg::DIV_N_W-1:0] quo_q;
	logic [woi_pkg::DIV_D_W-1:0] rem_q;
	logic [woi_pkg::DIV_D_W-1:0] d_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [woi_pkg::DIV_D_W:0]   sh;
	logic [woi_pkg::DIV_D_W:0]   diff;
	logic                        ge;

	always_comb begin
		sh   = {rem_q, quo_q[woi_pkg::DIV_N_W-1]};
		ge   = sh >= {1'b0, d_q};
		diff = sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(woi_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= n;
			rem_q <= '0;
			d_q   <= d;
		end else if (busy_q) begin
			rem_q <= ge ? diff[woi_pkg::DIV_D_W-1:0] : sh[woi_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[woi_pkg::DIV_N_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = quo_q;

endmodule

### rtl/wheel_odometry_integrator_top.sv
// ----------------------------------------------------------------------------
// wheel_odometry_integrator_top - differential-drive pose integrator
// Turns pairs of wheel encoder counts into a saturating pose, a wrapping
// heading, forward speed and turn rate, using serial arithmetic throughout.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload (lowest bits first)
//  -------  ---------  -------------------------------------------------------
//  s_*      in         left_count 16, right_count 16, elapsed_us 24
//  m_*      out        pos_x 32, pos_y 32, heading 32, speed 32, turn_rate 32
//  cfg_*    in         index 0 distance_per_count, index 1 turn_gain (32 bits)
//
// Each reading takes at most eight passes of the bit-serial multiplier and two
// of the divider, with the CORDIC rotation running alongside the first
// multiplication. With zero elapsed time the divisions are skipped. Reset
// clears the pose and restores the register defaults. A new reading is taken
// once the previous one has been worked out, even while its result still
// waits on a stalled output transfer.
module wheel_odometry_integrator_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [55:0]  s_tdata,   // left_count, right_count, elapsed_us
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,   // pos_x, pos_y, heading, speed, turn_rate
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MGO   = 3'd1;
	localparam logic [2:0] S_MWAIT = 3'd2;
	localparam logic [2:0] S_DGO   = 3'd3;
	localparam logic [2:0] S_DWAIT = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	localparam logic [2:0] OP_MEAN = 3'd0;
	localparam logic [2:0] OP_DIFF = 3'd1;
	localparam logic [2:0] OP_TURN = 3'd2;
	localparam logic [2:0] OP_X    = 3'd3;
	localparam logic [2:0] OP_Y    = 3'd4;
	localparam logic [2:0] OP_SPD  = 3'd5;
	localparam logic [2:0] OP_RMAG = 3'd6;
	localparam logic [2:0] OP_RMUL = 3'd7;

	localparam logic [63:0] MAG_LIMIT = 64'h0000_0800_0000_0000;
	localparam logic [63:0] MAG_CLAMP = 64'h0000_0100_0000_0000;

	localparam int CI_W_L = woi_pkg::CI_W;

	logic [2:0]  state_q;
	logic [2:0]  op_q;

	logic [31:0] dpc_q;
	logic [31:0] gain_q;
	logic [15:0] last_l_q;
	logic [15:0] last_r_q;
	logic        first_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [31:0] ang_q;

	logic [17:0] dsum_q;
	logic [17:0] ddif_q;
	logic [23:0] dt_q;
	logic [63:0] mean_q;
	logic [63:0] dist_q;
	logic [63:0] mag_q;
	logic [63:0] num_q;
	logic [31:0] speed_q;
	logic [31:0] rate_q;

	logic         out_valid_q;
	logic [159:0] out_data_q;

	// CORDIC rotation registers
	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic signed [32:0] cz_q;
	logic [CI_W_L-1:0]  ci_q;
	logic               crun_q;
	logic [1:0]         cquad_q;

	logic [15:0] in_l;
	logic [15:0] in_r;
	logic [15:0] base_l;
	logic [15:0] base_r;
	logic [16:0] dl;
	logic [16:0] dr;
	logic [31:0] quad_sum;
	logic [31:0] resid;

	logic signed [33:0] cos_v;
	logic signed [33:0] sin_v;
	logic [33:0]        cos_abs;
	logic [33:0]        sin_abs;
	logic [17:0]        dsum_abs;
	logic [17:0]        ddif_abs;
	logic [63:0]        mean_abs;
	logic [63:0]        dist_abs;
	logic [63:0]        step_v;
	logic [63:0]        step_abs;
	logic [4:0]         ck;
	logic [31:0]        catan;

	logic                         mul_start;
	logic [woi_pkg::MUL_A_W-1:0]  mul_a;
	logic [woi_pkg::MUL_B_W-1:0]  mul_b;
	logic                         mul_done;
	logic [woi_pkg::MUL_P_W-1:0]  mul_p;
	logic                         div_start;
	logic                         div_done;
	logic [woi_pkg::DIV_N_W-1:0]  div_q;

	logic [63:0] prod_lo;
	logic [63:0] sum_signed;
	logic [63:0] axis_v;
	logic        axis_neg;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Differences against the stored counts; the first reading seeds them.
	always_comb begin
		in_l     = s_tdata[15:0];
		in_r     = s_tdata[31:16];
		base_l   = first_q ? in_l : last_l_q;
		base_r   = first_q ? in_r : last_r_q;
		dl       = {in_l[15], in_l} - {base_l[15], base_l};
		dr       = {in_r[15], in_r} - {base_r[15], base_r};
		quad_sum = ang_q + 32'h2000_0000;
		resid    = ang_q - {quad_sum[31:30], 30'd0};
	end

	// Quadrant fold of the rotated vector, and operand magnitudes.
	always_comb begin
		case (cquad_q)
			2'd0: begin
				cos_v = cx_q;
				sin_v = cy_q;
			end
			2'd1: begin
				cos_v = -cy_q;
				sin_v = cx_q;
			end
			2'd2: begin
				cos_v = -cx_q;
				sin_v = -cy_q;
			end
			default: begin
				cos_v = cy_q;
				sin_v = -cx_q;
			end
		endcase
		cos_abs  = cos_v[33] ? 34'(-cos_v) : cos_v;
		sin_abs  = sin_v[33] ? 34'(-sin_v) : sin_v;
		dsum_abs = dsum_q[17] ? 18'(-dsum_q) : dsum_q;
		ddif_abs = ddif_q[17] ? 18'(-ddif_q) : ddif_q;
		mean_abs = mean_q[63] ? 64'(-mean_q) : mean_q;
		dist_abs = dist_q[63] ? 64'(-dist_q) : dist_q;
		step_v   = 64'($signed(mean_q) >>> 16);
		step_abs = step_v[63] ? 64'(-step_v) : step_v;
		ck       = 5'(ci_q);
		catan    = woi_pkg::atan_lut(ck);
	end

	always_comb begin
		case (op_q)
			OP_MEAN: begin
				mul_a = {46'd0, dsum_abs};
				mul_b = dpc_q;
			end
			OP_DIFF: begin
				mul_a = {46'd0, ddif_abs};
				mul_b = dpc_q;
			end
			OP_TURN: begin
				mul_a = dist_q;
				mul_b = gain_q;
			end
			OP_X: begin
				mul_a = step_abs;
				mul_b = cos_abs[31:0];
			end
			OP_Y: begin
				mul_a = step_abs;
				mul_b = sin_abs[31:0];
			end
			OP_SPD: begin
				mul_a = mean_abs;
				mul_b = 32'd15625;
			end
			OP_RMAG: begin
				mul_a = dist_abs;
				mul_b = gain_q;
			end
			default: begin
				mul_a = mag_q;
				mul_b = 32'd1000000;
			end
		endcase
	end

	// Post-processing of a finished product: sign restoration for the mean sum
	// and for each position product, whose arithmetic shift follows in the sequencer.
	always_comb begin
		prod_lo    = mul_p[63:0];
		sum_signed = dsum_q[17] ? 64'(-prod_lo) : prod_lo;
		axis_neg   = step_v[63] ^ ((op_q == OP_X) ? cos_v[33] : sin_v[33]);
		axis_v     = axis_neg ? 64'(-prod_lo) : prod_lo;
	end

	assign mul_start = (state_q == S_MGO);
	assign div_start = (state_q == S_DGO);

	woi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	woi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (num_q),
		.d      (dt_q),
		.done   (div_done),
		.q      (div_q)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q  <= woi_pkg::DPC_RESET;
			gain_q <= woi_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				woi_pkg::REG_DIST_PER_COUNT: dpc_q  <= cfg_wdata;
				woi_pkg::REG_TURN_GAIN:      gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// CORDIC: one micro-rotation per cycle from the heading held at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crun_q <= 1'b0;
			ci_q   <= '0;
		end else if (state_q == S_IDLE && s_tvalid) begin
			crun_q <= 1'b1;
			ci_q   <= '0;
		end else if (crun_q) begin
			ci_q <= ci_q + 1'b1;
			if (ci_q == CI_W_L'(woi_pkg::CORDIC_STEPS - 1))
				crun_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			cx_q    <= woi_pkg::CORDIC_GAIN;
			cy_q    <= '0;
			cz_q    <= {resid[31], resid};
			cquad_q <= quad_sum[31:30];
		end else if (crun_q) begin
			if (!cz_q[32]) begin
				cx_q <= cx_q - (cy_q >>> ck);
				cy_q <= cy_q + (cx_q >>> ck);
				cz_q <= cz_q - $signed({1'b0, catan});
			end else begin
				cx_q <= cx_q + (cy_q >>> ck);
				cy_q <= cy_q - (cx_q >>> ck);
				cz_q <= cz_q + $signed({1'b0, catan});
			end
		end
	end

	// Sequencer and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_MEAN;
			last_l_q    <= '0;
			last_r_q    <= '0;
			first_q     <= 1'b1;
			x_q         <= '0;
			y_q         <= '0;
			ang_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A result that leaves while the next one is finished is replaced
			// by the finishing step below.
			if (out_valid_q && m_tready && state_q != S_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						last_l_q <= in_l;
						last_r_q <= in_r;
						first_q  <= 1'b0;
						op_q     <= OP_MEAN;
						state_q  <= S_MGO;
					end
				end
				S_MGO: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (mul_done) begin
						case (op_q)
							OP_MEAN: begin
								op_q    <= OP_DIFF;
								state_q <= S_MGO;
							end
							OP_DIFF: begin
								op_q    <= OP_TURN;
								state_q <= S_MGO;
							end
							OP_TURN: begin
								ang_q   <= ang_q + mul_p[63:32];
								op_q    <= OP_X;
								state_q <= S_MGO;
							end
							OP_X: begin
								x_q     <= woi_pkg::sat_add(x_q, 64'($signed(axis_v) >>> 30));
								op_q    <= OP_Y;
								state_q <= S_MGO;
							end
							OP_Y: begin
								y_q <= woi_pkg::sat_add(y_q, 64'($signed(axis_v) >>> 30));
								if (dt_q == '0) begin
									state_q <= S_FIN;
								end else begin
									op_q    <= OP_SPD;
									state_q <= S_MGO;
								end
							end
							OP_SPD: state_q <= S_DGO;
							OP_RMAG: begin
								if (mul_p[95:32] >= MAG_LIMIT) begin
									state_q <= S_FIN;
								end else begin
									op_q    <= OP_RMUL;
									state_q <= S_MGO;
								end
							end
							default: state_q <= S_DGO;
						endcase
					end
				end
				S_DGO: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						if (op_q == OP_SPD) begin
							op_q    <= OP_RMAG;
							state_q <= S_MGO;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of one reading
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					dsum_q  <= {dl[16], dl} + {dr[16], dr};
					ddif_q  <= {dr[16], dr} - {dl[16], dl};
					dt_q    <= s_tdata[55:32];
					speed_q <= '0;
					rate_q  <= '0;
				end
			end
			S_MWAIT: begin
				if (mul_done) begin
					case (op_q)
						OP_MEAN: mean_q <= 64'($signed(sum_signed) >>> 1);
						OP_DIFF: dist_q <= ddif_q[17] ? 64'(-prod_lo) : prod_lo;
						OP_SPD:  num_q  <= mul_p[73:10];
						OP_RMAG: begin
							mag_q  <= mul_p[95:32];
							rate_q <= woi_pkg::sat_rate(dist_q[63], MAG_CLAMP);
						end
						OP_RMUL: num_q <= prod_lo;
						default: ;
					endcase
				end
			end
			S_DWAIT: begin
				if (div_done) begin
					if (op_q == OP_SPD)
						speed_q <= woi_pkg::sat_rate(mean_q[63], div_q);
					else
						rate_q <= woi_pkg::sat_rate(dist_q[63], div_q);
				end
			end
			S_FIN: begin
				if (!out_valid_q || m_tready)
					out_data_q <= {rate_q, speed_q, ang_q, y_q, x_q};
			end
			default: ;
		endcase
	end

endmodule

### test/wheel_odometry_integrator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_odometry_integrator_top_test - self-checking bench for the integrator
// Drives encoder readings under random idling on both streams, rewrites both
// registers between phases, and compares every pose result field by field
// against a bench model of the odometry or a pose typed into the table.
// ----------------------------------------------------------------------------
module wheel_odometry_integrator_top_test;

	typedef struct packed {
		logic [31:0] turn_rate;
		logic [31:0] speed;
		logic [31:0] heading;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
	} pose_t;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [23:0]        dt_us;
		logic               known;   // expected pose typed into the row
		pose_t              pose;
	} reading_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [55:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_wdata;

	// Bench copy of the registers and the odometry state.
	logic [31:0]        dpc_m, gain_m;
	logic [15:0]        prev_l, prev_r;
	logic               seed_pending;
	logic signed [31:0] x_m, y_m;
	logic [31:0]        ang_m;

	pose_t pose_q[$];
	int    fail_count;
	int    send_idle_pct, recv_idle_pct;

	wheel_odometry_integrator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous bound for all readings, idling included.
	initial begin
		#40ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic signed [63:0] sra(input logic signed [63:0] v, input int s);
		return v >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'h7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// Cosine and sine of a binary angle, scaled by 2^30, by a vectorless
	// CORDIC rotation after folding the angle into one quadrant.
	task automatic heading_trig(input logic [31:0] ang,
			output logic signed [63:0] c, output logic signed [63:0] s);
		logic [1:0]         q;
		logic [31:0]        res;
		logic signed [63:0] z, x, y, nx;
		q   = 2'((ang + 32'h20000000) >> 30);
		res = ang - {q, 30'd0};
		z   = 64'($signed(res));
		x   = 64'sh26DD3B6A;
		y   = 0;
		for (int i = 0; i < woi_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - sra(y, i);
				y  = y + sra(x, i);
				z  = z - woi_pkg::atan_lut(5'(i));
			end else begin
				nx = x + sra(y, i);
				y  = y - sra(x, i);
				z  = z + woi_pkg::atan_lut(5'(i));
			end
			x = nx;
		end
		case (q)
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	// Advance the bench odometry by one reading and return the pose it reports.
	task automatic integrate_reading(input logic signed [15:0] l, input logic signed [15:0] r,
			input logic [23:0] dt, output pose_t p);
		logic signed [63:0]  dl, dr, mean, stride, c, s, turn;
		logic signed [63:0]  spd, rate;
		logic [63:0]         mag, q;
		logic [127:0]        wide;
		logic                neg;
		if (seed_pending) begin
			prev_l = l;
			prev_r = r;
			seed_pending = 1'b0;
		end
		dl   = 64'(l) - 64'($signed(prev_l));
		dr   = 64'(r) - 64'($signed(prev_r));
		mean = sra(dl * $signed({32'd0, dpc_m}) + dr * $signed({32'd0, dpc_m}), 1);
		heading_trig(ang_m, c, s);
		stride = sra(mean, 16);
		x_m  = clamp32(64'(x_m) + sra(stride * c, 30));
		y_m  = clamp32(64'(y_m) + sra(stride * s, 30));
		turn = (dr - dl) * $signed({32'd0, dpc_m});
		wide = 128'(64'(turn)) * 128'(gain_m);
		ang_m = ang_m + wide[63:32];
		spd  = 0;
		rate = 0;
		if (dt != 0) begin
			neg = mean < 0;
			mag = neg ? 64'(-mean) : 64'(mean);
			q   = (mag * 64'd15625) / (64'(dt) * 64'd1024);
			spd = neg ? -$signed(q) : $signed(q);
			neg = turn < 0;
			mag = neg ? 64'(-turn) : 64'(turn);
			mag = (mag >> 32) * gain_m + (((mag & 64'hFFFFFFFF) * gain_m) >> 32);
			q   = (mag >= (64'd1 << 43)) ? (64'd1 << 40) : (mag * 64'd1000000) / 64'(dt);
			rate = neg ? -$signed(q) : $signed(q);
		end
		prev_l = l;
		prev_r = r;
		p.pos_x     = x_m;
		p.pos_y     = y_m;
		p.heading   = ang_m;
		p.speed     = clamp32(spd);
		p.turn_rate = clamp32(rate);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
		fail_count++;
	endtask

	// Result checker: each output transfer is compared with the oldest pose.
	always @(posedge clk) begin
		pose_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pose_q.size() == 0) begin
				$display("unexpected result transfer at %0t", $realtime);
				fail_count++;
			end else begin
				want = pose_q.pop_front();
				if (got.pos_x !== want.pos_x)
					report_mismatch("pos_x", got.pos_x, want.pos_x);
				if (got.pos_y !== want.pos_y)
					report_mismatch("pos_y", got.pos_y, want.pos_y);
				if (got.heading !== want.heading)
					report_mismatch("heading", got.heading, want.heading);
				if (got.speed !== want.speed)
					report_mismatch("speed", got.speed, want.speed);
				if (got.turn_rate !== want.turn_rate)
					report_mismatch("turn_rate", got.turn_rate, want.turn_rate);
			end
		end
	end

	// Receiver stalls follow the current idling percentage.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Hand one reading to the block, with optional idle cycles in front of it.
	// tvalid stays high after the transfer until the next reading or an idle
	// cycle replaces it; the block is busy by then, so nothing is taken twice.
	task automatic send_reading(input logic signed [15:0] l, input logic signed [15:0] r,
			input logic [23:0] dt);
		pose_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {dt, r, l};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		integrate_reading(l, r, dt, p);
		pose_q.push_back(p);
	endtask

	// Block is idle only when every pose has been returned and the last
	// reading has left the pipeline.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pose_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		if (idx == woi_pkg::REG_DIST_PER_COUNT)
			dpc_m = val;
		else
			gain_m = val;
	endtask

	// Random readings: mostly small motions around the previous counts so the
	// pose builds up, with occasional wild jumps and extreme times.
	task automatic random_readings(input int n);
		logic signed [15:0] l, r;
		logic [23:0]        dt;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 7) begin
				l = $signed(prev_l) + 16'($signed($urandom_range(400)) - 200);
				r = $signed(prev_r) + 16'($signed($urandom_range(400)) - 200);
			end else begin
				l = 16'($urandom);
				r = 16'($urandom);
			end
			case ($urandom_range(5))
				0: dt = 24'd1;
				1: dt = 24'hFFFFFF;
				2: dt = 24'($urandom);
				default: dt = 24'($urandom_range(50000, 1000));
			endcase
			send_reading(l, r, dt);
		end
	endtask

	reading_row_t rows[$];

	initial begin
		reading_row_t row;
		pose_t        p;
		fail_count    = 0;
		send_idle_pct = 25;
		recv_idle_pct = 64;
		dpc_m         = woi_pkg::DPC_RESET;
		gain_m        = woi_pkg::GAIN_RESET;
		prev_l        = '0;
		prev_r        = '0;
		seed_pending  = 1'b1;
		x_m           = '0;
		y_m           = '0;
		ang_m         = '0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_index     = woi_pkg::REG_DIST_PER_COUNT;
		cfg_wdata     = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. The first reading only seeds the counts, so its pose
		// is all zero; the zero-motion row after it must stay at rest.
		rows = '{
			'{16'sd1234, -16'sd77, 24'd1000, 1'b1, '0},
			'{16'sd1234, -16'sd77, 24'd1, 1'b1, '0},
			'{16'sd1334, 16'sd23, 24'd1000, 1'b0, '0},
			'{16'sd2000, 16'sd500, 24'd0, 1'b0, '0},
			'{16'sh7FFF, 16'sh7FFF, 24'd1, 1'b0, '0},
			'{-16'sh8000, -16'sh8000, 24'hFFFFFF, 1'b0, '0},
			'{16'sh7FFF, -16'sh8000, 24'd1, 1'b0, '0},
			'{-16'sh8000, 16'sh7FFF, 24'd1, 1'b0, '0},
			'{16'sd0, 16'sd0, 24'h800000, 1'b0, '0},
			'{-16'sd1, 16'sd1, 24'd12345, 1'b0, '0},
			'{16'sh5555, 16'shAAAA, 24'h555555, 1'b0, '0},
			'{16'shAAAA, 16'sh5555, 24'hAAAAAA, 1'b0, '0},
			'{16'sh7FFF, 16'sh7000, 24'd1, 1'b0, '0}
		};
		foreach (rows[i]) begin
			row = rows[i];
			send_reading(row.left, row.right, row.dt_us);
			// Replace the predicted pose with the typed one where given.
			if (row.known) begin
				p = pose_q.pop_back();
				pose_q.push_back(row.pose);
			end
		end

		// The sender holds off here until every pose is back.
		drain_results();
		random_readings(120);

		drain_results();
		write_reg(woi_pkg::REG_DIST_PER_COUNT, 32'hFFFFFFFF);
		write_reg(woi_pkg::REG_TURN_GAIN, 32'hFFFFFFFF);
		send_reading(16'sh7FFF, -16'sh8000, 24'd1);
		send_reading(-16'sh8000, 16'sh7FFF, 24'd1);
		random_readings(40);

		drain_results();
		send_idle_pct = 64;
		recv_idle_pct = 25;
		write_reg(woi_pkg::REG_DIST_PER_COUNT, 32'd0);
		write_reg(woi_pkg::REG_TURN_GAIN, 32'd0);
		random_readings(30);

		drain_results();
		write_reg(woi_pkg::REG_DIST_PER_COUNT, $urandom);
		write_reg(woi_pkg::REG_TURN_GAIN, $urandom);
		random_readings(100);

		drain_results();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(woi_pkg::REG_DIST_PER_COUNT, woi_pkg::DPC_RESET);
		write_reg(woi_pkg::REG_TURN_GAIN, woi_pkg::GAIN_RESET);
		random_readings(100);

		drain_results();
		repeat (500) @(posedge clk);
		if (fail_count == 0 && pose_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
